FILE: hdl/nearest_point_match_assert.svh
// Assertion macros used by the nearest point match top level.
`ifndef NEAREST_POINT_MATCH_ASSERT_SVH
`define NEAREST_POINT_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define NPM_ASSERT(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("nearest_point_match assertion failed");
`define NPM_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clock) prop) \
   else $error("nearest_point_match assertion failed");
`else
`define NPM_ASSERT(lbl, prop)
`define NPM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/npm_pkg.sv
// Shared types, widths and codes of the nearest point match block.
package npm_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int FRAC_BITS   = 8;

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W   = 25;
   localparam int DELTA_W = POS_W + 1;
   localparam int ABS_W   = POS_W;
   localparam int SQ_W    = 2 * ABS_W;
   localparam int DSQ_W   = 52;
   localparam int LIM_W   = 24;
   localparam int DIM_W   = 16;
   localparam int WFIX_W  = DIM_W + FRAC_BITS;
   localparam int CMP_W   = (POS_W + 1 > WFIX_W + 2) ? POS_W + 1 : WFIX_W + 2;
   localparam int MIDX_W  = 10;
   localparam int MCNT_W  = 16;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_MATCHED  = 2'd0,
      STAT_OUTSIDE  = 2'd1,
      STAT_NO_MATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_MATCH_LIMIT  = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                    valid;
      logic [IDX_W-1:0]        idx;
      logic signed [POS_W-1:0] ref_x;
      logic signed [POS_W-1:0] ref_y;
   } dist_req_type;

   typedef struct packed {
      logic                      valid;
      logic [IDX_W-1:0]          idx;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [DSQ_W-1:0]          dsq;
   } dist_res_type;

endpackage

FILE: hdl/nearest_point_match.sv
// Top level of the nearest point match block: table, scan sequencer, CSRs.
//
// Nearest point match. Load transactions (command 1) append a reference point
// to a table of up to TABLE_DEPTH entries; loads past a full table are
// dropped. A clear transaction (command 0) empties the table and zeroes the
// batch match count. A query transaction (command 2) returns one result: a
// query outside the image (x or y below 1.0 pixel or above width-1 / height-1
// pixels) reports status 1, otherwise every loaded entry is scanned for the
// nearest point by squared Euclidean distance, the lowest index winning a tie,
// and the winner is a match (status 0) only when its squared distance lies
// below both (width in pixels)^2 and match_limit^2; else status 2. Unmatched
// results carry zero index, deltas and distance. match_count saturates at
// 65535 and returns to zero after a query flagged last_query. For a query
// inside the image, the table's single read port feeds one entry per cycle
// into a pipelined distance unit (differences, squares, sum), which then
// drains before the verdict. An outside query or an empty table skips the
// scan and goes from ST_IDLE straight to ST_DONE. The block turns ready
// again together with rsp_valid when a result loads. It accepts no
// transaction during a scan, but does accept one while an earlier result
// still waits on rsp; a query that finishes meanwhile holds, input stalled,
// until rsp takes the earlier result.
// Configuration registers sit at byte offsets 0 (match_limit), 4
// (image_width) and 8 (image_height) of the APB-style port.
`include "nearest_point_match_assert.svh"
module nearest_point_match (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [npm_pkg::CMD_W-1:0]              req_command,
   input  logic signed [npm_pkg::POS_W-1:0]       req_pos_x,
   input  logic signed [npm_pkg::POS_W-1:0]       req_pos_y,
   input  logic                                   req_last_query,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [npm_pkg::STAT_W-1:0]             rsp_status,
   output logic [npm_pkg::MIDX_W-1:0]             rsp_match_index,
   output logic signed [npm_pkg::DELTA_W-1:0]     rsp_delta_x,
   output logic signed [npm_pkg::DELTA_W-1:0]     rsp_delta_y,
   output logic [npm_pkg::DSQ_W-1:0]              rsp_distance_sq,
   output logic [npm_pkg::MCNT_W-1:0]             rsp_match_count,
   // configuration port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [npm_pkg::ADDR_W-1:0]             paddr,
   input  logic [npm_pkg::DATA_W-1:0]             pwdata,
   output logic [npm_pkg::DATA_W-1:0]             prdata,
   output logic                                   pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   localparam logic signed [npm_pkg::CMP_W-1:0] ONE_FIX =
      npm_pkg::CMP_W'(64'd1 << npm_pkg::FRAC_BITS);
   localparam logic [npm_pkg::CNT_W-1:0] DEPTH_CNT =
      npm_pkg::CNT_W'(npm_pkg::TABLE_DEPTH);
   localparam logic [npm_pkg::MCNT_W-1:0] COUNT_MAX = '1;

   // ---------------------------------------------------------------- CSRs
   logic [npm_pkg::LIM_W-1:0] match_limit_ff;
   logic [npm_pkg::DIM_W-1:0] image_width_ff, image_height_ff;
   logic                      csr_write;
   npm_pkg::reg_index_type    csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = npm_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         match_limit_ff  <= npm_pkg::LIM_W'(384);
         image_width_ff  <= npm_pkg::DIM_W'(2048);
         image_height_ff <= npm_pkg::DIM_W'(2048);
      end else if (csr_write) begin
         unique case (csr_index)
            npm_pkg::REG_MATCH_LIMIT:  match_limit_ff  <= pwdata[npm_pkg::LIM_W-1:0];
            npm_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[npm_pkg::DIM_W-1:0];
            npm_pkg::REG_IMAGE_HEIGHT: image_height_ff <= pwdata[npm_pkg::DIM_W-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         npm_pkg::REG_MATCH_LIMIT:  prdata = npm_pkg::DATA_W'(match_limit_ff);
         npm_pkg::REG_IMAGE_WIDTH:  prdata = npm_pkg::DATA_W'(image_width_ff);
         npm_pkg::REG_IMAGE_HEIGHT: prdata = npm_pkg::DATA_W'(image_height_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- control
   state_type                          state_ff, state_in;
   logic [npm_pkg::CNT_W-1:0]          entry_cnt_ff, entry_cnt_in;
   logic [npm_pkg::MCNT_W-1:0]         batch_ff, batch_in;
   logic [npm_pkg::IDX_W-1:0]          scan_addr_ff, scan_addr_in;
   logic                               rd_valid_ff, rd_valid_in;
   logic [npm_pkg::IDX_W-1:0]          rd_idx_ff;
   logic [2*npm_pkg::POS_W-1:0]        rd_data_ff;
   logic                               rsp_valid_ff, rsp_valid_in;

   // query context
   logic signed [npm_pkg::POS_W-1:0]   qx_ff, qy_ff;
   logic                               last_ff, inside_ff;
   logic [2*npm_pkg::LIM_W-1:0]        lim_sq_ff;
   logic [npm_pkg::DSQ_W-1:0]          best_ff;
   logic [npm_pkg::IDX_W-1:0]          best_idx_ff;
   logic signed [npm_pkg::DELTA_W-1:0] best_dx_ff, best_dy_ff;
   logic                               found_ff;

   // result register
   npm_pkg::status_type                rsp_status_ff;
   logic [npm_pkg::MIDX_W-1:0]         rsp_index_ff;
   logic signed [npm_pkg::DELTA_W-1:0] rsp_dx_ff, rsp_dy_ff;
   logic [npm_pkg::DSQ_W-1:0]          rsp_dsq_ff;
   logic [npm_pkg::MCNT_W-1:0]         rsp_count_ff;

   logic                               accept, is_clear, is_load, is_query;
   logic                               inside_now, scan_last, done_fire, matched;
   logic [npm_pkg::MCNT_W-1:0]         count_new;
   logic signed [npm_pkg::CMP_W-1:0]   qx_ext, qy_ext, hx, hy;
   logic [npm_pkg::WFIX_W-1:0]         wfix;
   npm_pkg::cmd_type                   cmd;

   npm_pkg::dist_req_type              dreq;
   npm_pkg::dist_res_type              dres;
   logic                               dist_busy;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign cmd       = npm_pkg::cmd_type'(req_command);

   always_comb begin
      is_clear = 1'b0;
      is_load  = 1'b0;
      is_query = 1'b0;
      unique case (cmd)
         npm_pkg::CMD_CLEAR: is_clear = accept;
         npm_pkg::CMD_LOAD:  is_load  = accept;
         npm_pkg::CMD_QUERY: is_query = accept;
         default: ;  // unused command: drop the transaction
      endcase
   end

   // Image bounds, inclusive, in fixed point; a zero dimension falls below 1.0.
   always_comb begin
      qx_ext = npm_pkg::CMP_W'(req_pos_x);
      qy_ext = npm_pkg::CMP_W'(req_pos_y);
      hx = $signed(npm_pkg::CMP_W'({image_width_ff, {npm_pkg::FRAC_BITS{1'b0}}})) - ONE_FIX;
      hy = $signed(npm_pkg::CMP_W'({image_height_ff, {npm_pkg::FRAC_BITS{1'b0}}})) - ONE_FIX;
      inside_now = (qx_ext >= ONE_FIX) && (qx_ext <= hx) &&
                   (qy_ext >= ONE_FIX) && (qy_ext <= hy);
      wfix = {image_width_ff, {npm_pkg::FRAC_BITS{1'b0}}};
   end

   assign scan_last = (npm_pkg::CNT_W'(scan_addr_ff) + 1'b1) == entry_cnt_ff;
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign matched   = found_ff && (best_ff < npm_pkg::DSQ_W'(lim_sq_ff));
   assign count_new = (matched && (batch_ff != COUNT_MAX)) ? batch_ff + 1'b1 : batch_ff;

   always_comb begin
      state_in     = state_ff;
      entry_cnt_in = entry_cnt_ff;
      batch_in     = batch_ff;
      scan_addr_in = scan_addr_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_clear) begin
               entry_cnt_in = '0;
               batch_in     = '0;
            end
            if (is_load && (entry_cnt_ff < DEPTH_CNT)) begin
               entry_cnt_in = entry_cnt_ff + 1'b1;
            end
            if (is_query) begin
               scan_addr_in = '0;
               // skip the scan for an outside query or an empty table
               state_in = (inside_now && (entry_cnt_ff != '0)) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               batch_in     = last_ff ? '0 : count_new;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entry_cnt_ff <= '0;
         batch_ff     <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_cnt_ff <= entry_cnt_in;
         batch_ff     <= batch_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- table
   logic [2*npm_pkg::POS_W-1:0] table_mem [npm_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (is_load && (entry_cnt_ff < DEPTH_CNT)) begin
         table_mem[entry_cnt_ff[npm_pkg::IDX_W-1:0]] <= {req_pos_x, req_pos_y};
      end
      rd_data_ff <= table_mem[scan_addr_ff];
      rd_idx_ff  <= scan_addr_ff;
   end

   assign dreq.valid = rd_valid_ff;
   assign dreq.idx   = rd_idx_ff;
   assign dreq.ref_x = rd_data_ff[2*npm_pkg::POS_W-1:npm_pkg::POS_W];
   assign dreq.ref_y = rd_data_ff[npm_pkg::POS_W-1:0];

   npm_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .query_x (qx_ff),
      .query_y (qy_ff),
      .req     (dreq),
      .res     (dres),
      .busy    (dist_busy)
   );

   // ---------------------------------------------------------------- best tracking
   always_ff @(posedge clock) begin
      if (is_query) begin
         qx_ff     <= req_pos_x;
         qy_ff     <= req_pos_y;
         last_ff   <= req_last_query;
         inside_ff <= inside_now;
         lim_sq_ff <= match_limit_ff * match_limit_ff;
         best_ff   <= npm_pkg::DSQ_W'(wfix * wfix);
         found_ff  <= 1'b0;
      end else if (dres.valid && (dres.dsq < best_ff)) begin
         // strict compare: the first entry keeps a tie
         best_ff     <= dres.dsq;
         best_idx_ff <= dres.idx;
         best_dx_ff  <= dres.dx;
         best_dy_ff  <= dres.dy;
         found_ff    <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_count_ff <= count_new;
         if (!inside_ff) begin
            rsp_status_ff <= npm_pkg::STAT_OUTSIDE;
         end else if (matched) begin
            rsp_status_ff <= npm_pkg::STAT_MATCHED;
         end else begin
            rsp_status_ff <= npm_pkg::STAT_NO_MATCH;
         end
         if (inside_ff && matched) begin
            rsp_index_ff <= npm_pkg::MIDX_W'(best_idx_ff);
            rsp_dx_ff    <= best_dx_ff;
            rsp_dy_ff    <= best_dy_ff;
            rsp_dsq_ff   <= best_ff;
         end else begin
            rsp_index_ff <= '0;
            rsp_dx_ff    <= '0;
            rsp_dy_ff    <= '0;
            rsp_dsq_ff   <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_delta_x     = rsp_dx_ff;
   assign rsp_delta_y     = rsp_dy_ff;
   assign rsp_distance_sq = rsp_dsq_ff;
   assign rsp_match_count = rsp_count_ff;

   // ---------------------------------------------------------------- checks
   `NPM_ASSERT(a_scan_nonempty, (state_ff == ST_SCAN) |-> (entry_cnt_ff != '0))
   `NPM_ASSERT(a_read_in_range, rd_valid_ff |-> (npm_pkg::CNT_W'(rd_idx_ff) < entry_cnt_ff))
   `NPM_ASSERT(a_pipe_only_scan, dres.valid |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
   `NPM_ASSERT(a_done_drained, (state_ff == ST_DONE) |-> (!rd_valid_ff && !dist_busy))
   `NPM_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))

endmodule

FILE: hdl/npm_dist_unit.sv
// Pipelined squared distance unit shared by every entry of a table scan.
module npm_dist_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic signed [npm_pkg::POS_W-1:0]          query_x,
   input  logic signed [npm_pkg::POS_W-1:0]          query_y,
   input  npm_pkg::dist_req_type                     req,
   output npm_pkg::dist_res_type                     res,
   output logic                                      busy
);

   // stage 1: differences and magnitudes
   logic                                  s1_valid_ff, s1_valid_in;
   logic [npm_pkg::IDX_W-1:0]             s1_idx_ff;
   logic signed [npm_pkg::DELTA_W-1:0]    s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [npm_pkg::ABS_W-1:0]             s1_ax_ff, s1_ay_ff, s1_ax_in, s1_ay_in;
   // stage 2: squares
   logic                                  s2_valid_ff, s2_valid_in;
   logic [npm_pkg::IDX_W-1:0]             s2_idx_ff;
   logic signed [npm_pkg::DELTA_W-1:0]    s2_dx_ff, s2_dy_ff;
   logic [npm_pkg::SQ_W-1:0]              s2_sqx_ff, s2_sqy_ff;
   // stage 3: sum
   npm_pkg::dist_res_type                 res_ff, res_in;

   always_comb begin
      logic signed [npm_pkg::DELTA_W-1:0] neg_x, neg_y;
      s1_dx_in = npm_pkg::DELTA_W'(query_x) - npm_pkg::DELTA_W'(req.ref_x);
      s1_dy_in = npm_pkg::DELTA_W'(query_y) - npm_pkg::DELTA_W'(req.ref_y);
      neg_x    = -s1_dx_in;
      neg_y    = -s1_dy_in;
      s1_ax_in = s1_dx_in[npm_pkg::DELTA_W-1] ? neg_x[npm_pkg::ABS_W-1:0]
                                              : s1_dx_in[npm_pkg::ABS_W-1:0];
      s1_ay_in = s1_dy_in[npm_pkg::DELTA_W-1] ? neg_y[npm_pkg::ABS_W-1:0]
                                              : s1_dy_in[npm_pkg::ABS_W-1:0];
      s1_valid_in = req.valid;
      s2_valid_in = s1_valid_ff;
      res_in.valid = s2_valid_ff;
      res_in.idx   = s2_idx_ff;
      res_in.dx    = s2_dx_ff;
      res_in.dy    = s2_dy_ff;
      res_in.dsq   = npm_pkg::DSQ_W'(s2_sqx_ff) + npm_pkg::DSQ_W'(s2_sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         res_ff.valid <= res_in.valid;
      end
      s1_idx_ff  <= req.idx;
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s1_ax_ff   <= s1_ax_in;
      s1_ay_ff   <= s1_ay_in;
      s2_idx_ff  <= s1_idx_ff;
      s2_dx_ff   <= s1_dx_ff;
      s2_dy_ff   <= s1_dy_ff;
      s2_sqx_ff  <= s1_ax_ff * s1_ax_ff;
      s2_sqy_ff  <= s1_ay_ff * s1_ay_ff;
      res_ff.idx <= res_in.idx;
      res_ff.dx  <= res_in.dx;
      res_ff.dy  <= res_in.dy;
      res_ff.dsq <= res_in.dsq;
   end

   assign res  = res_ff;
   assign busy = s1_valid_ff | s2_valid_ff | res_ff.valid;

endmodule

FILE: verif/nearest_point_match_tb.sv
// Self-checking testbench for the nearest point match block.
module nearest_point_match_tb;

   typedef logic signed [npm_pkg::POS_W-1:0] coord_type;

   // One result transaction as it leaves the block.
   typedef struct packed {
      npm_pkg::status_type                status;
      logic [npm_pkg::MIDX_W-1:0]         match_index;
      logic signed [npm_pkg::DELTA_W-1:0] delta_x;
      logic signed [npm_pkg::DELTA_W-1:0] delta_y;
      logic [npm_pkg::DSQ_W-1:0]          distance_sq;
      logic [npm_pkg::MCNT_W-1:0]         match_count;
   } match_result_type;

   // Command code 3 has no meaning; the block must swallow it silently.
   localparam logic [npm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int     ONE_PIXEL     = 1 << npm_pkg::FRAC_BITS;
   localparam int     POS_MAX       = (1 << (npm_pkg::POS_W - 1)) - 1;
   localparam int     POS_MIN       = -(1 << (npm_pkg::POS_W - 1));
   localparam int     LIMIT_MAX     = (1 << npm_pkg::LIM_W) - 1;
   localparam int     DIM_MAX       = (1 << npm_pkg::DIM_W) - 1;
   localparam int     RESET_LIMIT   = 384;
   localparam int     RESET_DIM     = 2048;
   localparam int     P100          = 100 * ONE_PIXEL;
   localparam int     FAR_EDGE      = (RESET_DIM - 1) * ONE_PIXEL;
   localparam int     MATCH_SAT     = (1 << npm_pkg::MCNT_W) - 1;
   localparam int     CHUNK_ITEMS   = 80;
   localparam int     WELL_FORMED   = 80;
   localparam int     WIDE_SPAN     = 4096;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     LONG_HOLD     = 3000;
   localparam longint RUN_LIMIT     = 20_000_000;

   // Scoreboard: tracks the table and batch state as transactions are
   // accepted, predicts each query result and checks the block's output.
   class match_scoreboard;
      logic [npm_pkg::LIM_W-1:0] match_limit;
      logic [npm_pkg::DIM_W-1:0] image_width;
      logic [npm_pkg::DIM_W-1:0] image_height;
      coord_type                 table_x [npm_pkg::TABLE_DEPTH];
      coord_type                 table_y [npm_pkg::TABLE_DEPTH];
      int unsigned               entry_count;
      int unsigned               batch_matches;
      match_result_type          pending_matches [$];
      int unsigned               mismatches;

      function new();
         match_limit   = RESET_LIMIT;
         image_width   = RESET_DIM;
         image_height  = RESET_DIM;
         entry_count   = 0;
         batch_matches = 0;
         mismatches    = 0;
      endfunction

      function void set_register(npm_pkg::reg_index_type r, logic [npm_pkg::DATA_W-1:0] v);
         case (r)
            npm_pkg::REG_MATCH_LIMIT:  match_limit  = v[npm_pkg::LIM_W-1:0];
            npm_pkg::REG_IMAGE_WIDTH:  image_width  = v[npm_pkg::DIM_W-1:0];
            npm_pkg::REG_IMAGE_HEIGHT: image_height = v[npm_pkg::DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending_count();
         return pending_matches.size();
      endfunction

      // Brute-force nearest search over the loaded entries.
      function match_result_type predict_search(coord_type x, coord_type y);
         match_result_type  r;
         longint            one, qx, qy, hx, hy, dx, dy, bdx, bdy;
         longint unsigned   wfix, best, lim, ax, ay, d;
         int unsigned       bi;
         bit                found;
         one   = longint'(1) << npm_pkg::FRAC_BITS;
         qx    = x;
         qy    = y;
         hx    = (longint'(image_width) - 1) * one;
         hy    = (longint'(image_height) - 1) * one;
         r     = '0;
         r.status = npm_pkg::STAT_OUTSIDE;
         if (qx >= one && qx <= hx && qy >= one && qy <= hy) begin
            wfix  = image_width;
            wfix  = wfix << npm_pkg::FRAC_BITS;
            best  = wfix * wfix;
            lim   = match_limit;
            lim   = lim * lim;
            found = 1'b0;
            bi    = 0;
            bdx   = 0;
            bdy   = 0;
            for (int unsigned j = 0; j < entry_count; j++) begin
               dx = qx - longint'(table_x[j]);
               dy = qy - longint'(table_y[j]);
               ax = (dx < 0) ? -dx : dx;
               ay = (dy < 0) ? -dy : dy;
               d  = ax * ax + ay * ay;
               // strict compare: the lowest index keeps a tie
               if (d < best) begin
                  best  = d;
                  bi    = j;
                  bdx   = dx;
                  bdy   = dy;
                  found = 1'b1;
               end
            end
            r.status = npm_pkg::STAT_NO_MATCH;
            if (found && best < lim) begin
               r.status      = npm_pkg::STAT_MATCHED;
               r.match_index = bi[npm_pkg::MIDX_W-1:0];
               r.delta_x     = bdx[npm_pkg::DELTA_W-1:0];
               r.delta_y     = bdy[npm_pkg::DELTA_W-1:0];
               r.distance_sq = best[npm_pkg::DSQ_W-1:0];
               if (batch_matches < MATCH_SAT) batch_matches++;
            end
         end
         r.match_count = batch_matches[npm_pkg::MCNT_W-1:0];
         return r;
      endfunction

      function void note_request(logic [npm_pkg::CMD_W-1:0] cmd, coord_type x, coord_type y,
                                 logic last);
         if (cmd == npm_pkg::CMD_CLEAR) begin
            entry_count   = 0;
            batch_matches = 0;
         end else if (cmd == npm_pkg::CMD_LOAD) begin
            // drop loads past a full table
            if (entry_count < npm_pkg::TABLE_DEPTH) begin
               table_x[entry_count] = x;
               table_y[entry_count] = y;
               entry_count++;
            end
         end else if (cmd == npm_pkg::CMD_QUERY) begin
            pending_matches.push_back(predict_search(x, y));
            if (last) batch_matches = 0;
         end
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         mismatches++;
         $display("mismatch %0d at %0t: %s got 0x%0h expected 0x%0h",
                  mismatches, $time, what, got, want);
      endtask

      task check_result(match_result_type got);
         match_result_type want;
         if (pending_matches.size() == 0) begin
            report_mismatch("result with nothing pending, status", got.status, 0);
         end else begin
            want = pending_matches.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.match_index !== want.match_index)
               report_mismatch("match_index", got.match_index, want.match_index);
            if (got.delta_x !== want.delta_x)
               report_mismatch("delta_x", $unsigned(got.delta_x), $unsigned(want.delta_x));
            if (got.delta_y !== want.delta_y)
               report_mismatch("delta_y", $unsigned(got.delta_y), $unsigned(want.delta_y));
            if (got.distance_sq !== want.distance_sq)
               report_mismatch("distance_sq", got.distance_sq, want.distance_sq);
            if (got.match_count !== want.match_count)
               report_mismatch("match_count", got.match_count, want.match_count);
         end
      endtask

      task close_out();
         if (pending_matches.size() != 0)
            report_mismatch("results never delivered", pending_matches.size(), 0);
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [npm_pkg::CMD_W-1:0]          req_command = npm_pkg::CMD_CLEAR;
   coord_type                          req_pos_x = '0;
   coord_type                          req_pos_y = '0;
   logic                               req_last_query = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [npm_pkg::STAT_W-1:0]         rsp_status;
   logic [npm_pkg::MIDX_W-1:0]         rsp_match_index;
   logic signed [npm_pkg::DELTA_W-1:0] rsp_delta_x;
   logic signed [npm_pkg::DELTA_W-1:0] rsp_delta_y;
   logic [npm_pkg::DSQ_W-1:0]          rsp_distance_sq;
   logic [npm_pkg::MCNT_W-1:0]         rsp_match_count;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [npm_pkg::ADDR_W-1:0]         paddr = '0;
   logic [npm_pkg::DATA_W-1:0]         pwdata = '0;
   logic [npm_pkg::DATA_W-1:0]         prdata;
   logic                               pready;

   match_scoreboard sb = new();

   // Idle odds in percent per cycle; the sender reads its own, the receiver
   // process picks its odds up at each edge.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned items_sent    = 0;

   // Long receiver hold-off: main flips the request bit, the receiver
   // process notices the change and counts the hold itself.
   logic        hold_toggle = 1'b0;
   logic        hold_ack    = 1'b0;
   int unsigned hold_left   = 0;

   nearest_point_match u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_last_query  (req_last_query),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_distance_sq (rsp_distance_sq),
      .rsp_match_count (rsp_match_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: check every transaction taken at this edge, then pick
   // ready for the next cycle. All values read here are pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{status:      npm_pkg::status_type'(rsp_status),
                           match_index: rsp_match_index,
                           delta_x:     rsp_delta_x,
                           delta_y:     rsp_delta_y,
                           distance_sq: rsp_distance_sq,
                           match_count: rsp_match_count});
      if (hold_toggle != hold_ack) begin
         hold_ack  <= hold_toggle;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request transaction, with random idle cycles ahead of it,
   // and hold it until the block takes it.
   task automatic send_item(logic [npm_pkg::CMD_W-1:0] cmd, coord_type x, coord_type y,
                            logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_last_query <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, x, y, last);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // Drop valid, wait for every pending result, then let loads and clears
   // still in flight settle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write (setup + access), then read the register back.
   task automatic write_register(npm_pkg::reg_index_type r, logic [npm_pkg::DATA_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(r, v);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== v) sb.report_mismatch("register readback", prdata, v);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_setting(int unsigned limit, int unsigned w, int unsigned h);
      wait_until_idle();
      write_register(npm_pkg::REG_MATCH_LIMIT, limit);
      write_register(npm_pkg::REG_IMAGE_WIDTH, w);
      write_register(npm_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   // Coordinate inside [1, dim-1] pixels, bounds hit often; any value when
   // the image has no inside at all.
   function automatic coord_type pick_coord(logic [npm_pkg::DIM_W-1:0] dim);
      int unsigned hi;
      if (dim < 2) return coord_type'($urandom());
      hi = (int'(dim) - 1) << npm_pkg::FRAC_BITS;
      case ($urandom_range(9))
         0:       return coord_type'(ONE_PIXEL);
         1:       return coord_type'(hi);
         default: return coord_type'($urandom_range(hi, ONE_PIXEL));
      endcase
   endfunction

   // Offset a coordinate by up to +/- span, clamped to the field range.
   function automatic coord_type nudge(coord_type c, int unsigned span);
      longint v;
      v = longint'(c) + longint'($urandom_range(2 * span)) - longint'(span);
      if (v > POS_MAX) v = POS_MAX;
      if (v < POS_MIN) v = POS_MIN;
      return coord_type'(v);
   endfunction

   // Mostly well-formed batches (optional clear, loads, queries aimed near
   // loaded entries), with some raw noise transactions mixed in.
   task automatic random_sequence();
      int unsigned loads, queries, span, pick;
      coord_type   qx, qy;
      logic        last;
      if ($urandom_range(99) >= WELL_FORMED) begin
         send_item(npm_pkg::CMD_W'($urandom_range(3)), coord_type'($urandom()),
                   coord_type'($urandom()), $urandom_range(1) == 1);
      end else begin
         if ($urandom_range(1) == 1)
            send_item(npm_pkg::CMD_CLEAR, coord_type'($urandom()), coord_type'($urandom()),
                      $urandom_range(1) == 1);
         loads = $urandom_range(12, 1);
         repeat (loads) begin
            if (sb.entry_count != 0 && $urandom_range(7) == 0) begin
               // duplicate an entry so ties turn up
               pick = $urandom_range(sb.entry_count - 1);
               send_item(npm_pkg::CMD_LOAD, sb.table_x[pick], sb.table_y[pick], 1'b0);
            end else begin
               send_item(npm_pkg::CMD_LOAD, pick_coord(sb.image_width),
                         pick_coord(sb.image_height), $urandom_range(3) == 0);
            end
         end
         // aim queries around the match radius, or the width if that is tighter, capped at WIDE_SPAN
         span = sb.match_limit;
         if (span > (int'(sb.image_width) << npm_pkg::FRAC_BITS))
            span = int'(sb.image_width) << npm_pkg::FRAC_BITS;
         if (span > WIDE_SPAN) span = WIDE_SPAN;
         span = span + span / 2 + 16;
         queries = $urandom_range(8, 1);
         for (int q = 1; q <= queries; q++) begin
            pick = $urandom_range(sb.entry_count - 1);
            if ($urandom_range(3) == 0) begin
               qx = pick_coord(sb.image_width);
               qy = pick_coord(sb.image_height);
            end else begin
               qx = nudge(sb.table_x[pick], span);
               qy = nudge(sb.table_y[pick], span);
            end
            last = (q == queries) ? ($urandom_range(9) < 7) : ($urandom_range(19) == 0);
            send_item(npm_pkg::CMD_QUERY, qx, qy, last);
         end
      end
   endtask

   initial begin
      int unsigned half_mark, chunk_mark;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset configuration (1.5 px limit, 2048 x 2048).
      send_item(npm_pkg::CMD_QUERY, P100, P100, 1'b0);               // empty table
      send_item(CMD_UNUSED, POS_MAX, POS_MIN, 1'b1);                 // must vanish
      send_item(npm_pkg::CMD_LOAD, P100, P100, 1'b1);                // batch flag ignored
      send_item(npm_pkg::CMD_LOAD, P100, P100, 1'b0);                // tie with entry 0
      send_item(npm_pkg::CMD_LOAD, P100 + 100, P100 - 50, 1'b0);
      send_item(npm_pkg::CMD_LOAD, POS_MAX, POS_MIN, 1'b0);
      send_item(npm_pkg::CMD_LOAD, POS_MIN, POS_MAX, 1'b0);
      send_item(npm_pkg::CMD_QUERY, P100, P100, 1'b0);               // exact hit, lowest index
      send_item(npm_pkg::CMD_QUERY, P100 + 200, P100 + 300, 1'b0);
      send_item(npm_pkg::CMD_QUERY, P100 - RESET_LIMIT, P100, 1'b0); // exactly on the limit
      send_item(npm_pkg::CMD_QUERY, ONE_PIXEL, ONE_PIXEL, 1'b0);     // low corner, inside
      send_item(npm_pkg::CMD_QUERY, ONE_PIXEL - 1, P100, 1'b0);
      send_item(npm_pkg::CMD_QUERY, P100, ONE_PIXEL - 1, 1'b0);
      send_item(npm_pkg::CMD_QUERY, FAR_EDGE, FAR_EDGE, 1'b0);       // high corner, inside
      send_item(npm_pkg::CMD_QUERY, FAR_EDGE + 1, P100, 1'b0);
      send_item(npm_pkg::CMD_QUERY, P100, FAR_EDGE + 1, 1'b0);
      send_item(npm_pkg::CMD_QUERY, POS_MAX, POS_MAX, 1'b0);
      send_item(npm_pkg::CMD_QUERY, POS_MIN, POS_MIN, 1'b1);         // ends the batch
      send_item(npm_pkg::CMD_QUERY, P100 + 1, P100 - 1, 1'b0);       // count restarts
      send_item(npm_pkg::CMD_CLEAR, P100, P100, 1'b1);
      send_item(npm_pkg::CMD_QUERY, P100, P100, 1'b1);
      send_item(CMD_UNUSED, 0, 0, 1'b0);

      // Random part: one register setting per chunk, extremes included.
      // Chunks 0-2: sender idles lightly, receiver heavily; 3-4 swap; 5-6 none.
      for (int chunk = 0; chunk < 7; chunk++) begin
         case (chunk)
            0: apply_setting(RESET_LIMIT, RESET_DIM, RESET_DIM);
            1: apply_setting(LIMIT_MAX, DIM_MAX, DIM_MAX);
            2: apply_setting(0, 1, 1);          // no inside at all
            3: apply_setting(1000, 64, 48);
            4: apply_setting(LIMIT_MAX, 8, 8);  // the width bound decides
            5: apply_setting(2000, 0, 0);       // zero-sized image
            default: apply_setting(5000, RESET_DIM, 300);
         endcase
         if (chunk < 3) begin
            send_idle_pct  = 21;
            recv_idle_pct <= 55;
         end else if (chunk < 5) begin
            send_idle_pct  = 55;
            recv_idle_pct <= 21;
         end else begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
         end
         // Back-pressure: stall the receiver for a long stretch while requests
         // keep coming, so the block fills up and holds off its input.
         if (chunk == 1) hold_toggle <= ~hold_toggle;
         half_mark  = items_sent + CHUNK_ITEMS / 2;
         chunk_mark = items_sent + CHUNK_ITEMS;
         while (items_sent < half_mark) random_sequence();
         // Sender pause: let every result come home before going on.
         if (chunk == 2) wait_until_idle();
         while (items_sent < chunk_mark) random_sequence();
      end

      wait_until_idle();
      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(RUN_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/npm_pkg.sv
hdl/npm_dist_unit.sv
hdl/nearest_point_match.sv
verif/nearest_point_match_tb.sv
